// File: design/lidar_packet_sample_decoder_assert.svh
// ----------------------------------------------------------------------------
// lidar_packet_sample_decoder_assert.svh
// Assertion macros shared by the sample decoder RTL.
// ----------------------------------------------------------------------------
`ifndef LIDAR_PACKET_SAMPLE_DECODER_ASSERT_SVH
`define LIDAR_PACKET_SAMPLE_DECODER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication, clocked on clk, idle while rst_n is low
`define LPSD_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lpsd assertion failed");
// next-cycle implication
`define LPSD_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lpsd assertion failed");
`else
`define LPSD_ASSERT_IMP(lbl, ante, cons)
`define LPSD_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: design/lpsd_pkg.sv
// ----------------------------------------------------------------------------
// lpsd_pkg
// Types and constants for the lidar packet sample decoder.
// ----------------------------------------------------------------------------
package lpsd_pkg;

  localparam logic [7:0]  HDR_FIRST  = 8'hAA;
  localparam logic [7:0]  HDR_SECOND = 8'h55;

  // angles in 1/64 degree
  localparam int unsigned SPAN_W    = 15;
  localparam logic [SPAN_W-1:0] FULL_TURN = 15'd23040;
  localparam logic [16:0] HALF_TURN = 17'd11520;

  localparam int unsigned PROD_W    = 23;  // span * index
  localparam int unsigned DIV_STEPS = PROD_W;
  localparam int unsigned CNT_W     = 5;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_SAMPLES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_DIST    = 2'd1;

  localparam logic [7:0]  MAX_SAMPLES_RST = 8'd120;
  localparam logic [15:0] MIN_DIST_RST    = 16'd80;

  typedef enum logic [1:0] {
    PH_WAIT1,
    PH_WAIT2,
    PH_META,
    PH_PAYLOAD
  } parse_phase_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_MUL,
    CS_DIV,
    CS_DONE
  } calc_state_t;

  typedef struct packed {
    logic       ld_first_lo;
    logic       ld_first_hi;
    logic       ld_last_lo;
    logic       ld_last_hi;
    logic       ld_dist_lo;
    logic       ld_dist_hi;
    logic       calc_start;
    logic       calc_mul;
    logic       div_step;
    logic       emit;
    logic [7:0] sample_idx;
    logic [7:0] sample_total;
  } dp_cmd_t;

  typedef struct packed {
    logic dist_gt;
  } dp_status_t;

endpackage

// File: design/lidar_packet_sample_decoder.sv
// A sample byte that yields a result stalls the input for 1 multiply, 23 divider
// steps and 1 result load, result valid on the cycle after. Throughput is bounded
// by the 1-bit-per-cycle serial divider.
// A result waiting at the output does not block bytes unless the next one is due.
// Reset (rst_n, synchronous, active low) returns the parser to the header hunt and
// restores max_samples to 120 and min_distance_raw to 80.
// ----------------------------------------------------------------------------
// lidar_packet_sample_decoder
// Byte-serial AA 55 lidar packet parser giving per-sample angle and distance.
// ----------------------------------------------------------------------------
`include "lidar_packet_sample_decoder_assert.svh"

module lidar_packet_sample_decoder (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lpsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpsd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [15:0]                     out_angle,
  output logic [15:0]                     out_distance_raw,
  output logic                            out_revolution_start,
  output logic                            out_previous_scan_complete
);
  import lpsd_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  lpsd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_rx_byte(in_rx_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .status    (status)
  );

  lpsd_dp u_dp (
    .clk                       (clk),
    .rst_n                     (rst_n),
    .cfg_we                    (cfg_we),
    .cfg_index                 (cfg_index),
    .cfg_wdata                 (cfg_wdata),
    .in_rx_byte                (in_rx_byte),
    .cmd                       (cmd),
    .status                    (status),
    .out_angle                 (out_angle),
    .out_distance_raw          (out_distance_raw),
    .out_revolution_start      (out_revolution_start),
    .out_previous_scan_complete(out_previous_scan_complete)
  );

  // no request is taken while a sample calculation is in flight
  `LPSD_ASSERT_IMP(a_no_accept_in_div, cmd.div_step || cmd.emit, in_stall)
  `LPSD_ASSERT_NXT(a_calc_stalls, cmd.calc_start, in_stall)
  `LPSD_ASSERT_NXT(a_emit_valid, cmd.emit, out_valid)
  `LPSD_ASSERT_IMP(a_emit_no_overwrite, cmd.emit, !out_valid || !out_stall)

endmodule

// File: design/lpsd_ctrl.sv
// ----------------------------------------------------------------------------
// lpsd_ctrl
// Packet parser and sample calculation sequencer.
// ----------------------------------------------------------------------------
module lpsd_ctrl (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lpsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpsd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [7:0]                      in_rx_byte,
  output logic                            out_valid,
  input  logic                            out_stall,
  output lpsd_pkg::dp_cmd_t               cmd,
  input  lpsd_pkg::dp_status_t            status
);
  import lpsd_pkg::*;

  parse_phase_t phase_r, phase_nxt;
  calc_state_t  cstate_r, cstate_nxt;
  logic [2:0]       hdr_pos_r, hdr_pos_nxt;
  logic [1:0]       sbp_r, sbp_nxt;
  logic [7:0]       idx_r, idx_nxt;
  logic [7:0]       total_r, total_nxt;
  logic [7:0]       max_samples_r;
  logic [CNT_W-1:0] div_cnt_r, div_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             accept;
  logic [7:0]       idx_inc;

  assign in_stall  = (cstate_r != CS_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign idx_inc   = idx_r + 8'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_samples_r <= MAX_SAMPLES_RST;
    end else if (cfg_we && cfg_index == CFG_MAX_SAMPLES) begin
      max_samples_r <= cfg_wdata[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_WAIT1;
      cstate_r    <= CS_IDLE;
      hdr_pos_r   <= 3'd0;
      sbp_r       <= 2'd0;
      idx_r       <= 8'd0;
      total_r     <= 8'd0;
      div_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      phase_r     <= phase_nxt;
      cstate_r    <= cstate_nxt;
      hdr_pos_r   <= hdr_pos_nxt;
      sbp_r       <= sbp_nxt;
      idx_r       <= idx_nxt;
      total_r     <= total_nxt;
      div_cnt_r   <= div_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    phase_nxt     = phase_r;
    cstate_nxt    = cstate_r;
    hdr_pos_nxt   = hdr_pos_r;
    sbp_nxt       = sbp_r;
    idx_nxt       = idx_r;
    total_nxt     = total_r;
    div_cnt_nxt   = div_cnt_r;
    out_valid_nxt = out_valid_r;
    cmd              = '0;
    cmd.sample_idx   = idx_r;
    cmd.sample_total = total_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // byte parser, only runs while no sample calculation is in flight
    if (accept) begin
      case (phase_r)
        PH_WAIT1: begin
          if (in_rx_byte == HDR_FIRST) begin
            phase_nxt = PH_WAIT2;
          end
        end
        PH_WAIT2: begin
          if (in_rx_byte == HDR_SECOND) begin
            phase_nxt   = PH_META;
            hdr_pos_nxt = 3'd0;
          end else if (in_rx_byte != HDR_FIRST) begin
            phase_nxt = PH_WAIT1;
          end
        end
        PH_META: begin
          if (hdr_pos_r == 3'd0) begin
            hdr_pos_nxt = 3'd1;  // type byte skipped
          end else if (in_rx_byte == 8'd0 || in_rx_byte > max_samples_r) begin
            phase_nxt   = PH_WAIT1;
            hdr_pos_nxt = 3'd0;
            idx_nxt     = 8'd0;
            sbp_nxt     = 2'd0;
          end else begin
            total_nxt   = in_rx_byte;
            idx_nxt     = 8'd0;
            sbp_nxt     = 2'd0;
            hdr_pos_nxt = 3'd0;
            phase_nxt   = PH_PAYLOAD;
          end
        end
        PH_PAYLOAD: begin
          if (hdr_pos_r < 3'd4) begin
            case (hdr_pos_r)
              3'd0:    cmd.ld_first_lo = 1'b1;
              3'd1:    cmd.ld_first_hi = 1'b1;
              3'd2:    cmd.ld_last_lo  = 1'b1;
              default: cmd.ld_last_hi  = 1'b1;
            endcase
            hdr_pos_nxt = hdr_pos_r + 3'd1;
          end else begin
            case (sbp_r)
              2'd0: begin
                cmd.ld_dist_lo = 1'b1;
                sbp_nxt        = 2'd1;
              end
              2'd1: begin
                cmd.ld_dist_hi = 1'b1;
                sbp_nxt        = 2'd2;
              end
              default: begin
                if (status.dist_gt) begin
                  cmd.calc_start = 1'b1;
                  cstate_nxt     = CS_MUL;
                end
                sbp_nxt = 2'd0;
                idx_nxt = idx_inc;
                if (idx_inc >= total_r) begin
                  phase_nxt   = PH_WAIT1;
                  hdr_pos_nxt = 3'd0;
                  idx_nxt     = 8'd0;
                end
              end
            endcase
          end
        end
        default: phase_nxt = PH_WAIT1;
      endcase
    end

    case (cstate_r)
      CS_IDLE: ;
      CS_MUL: begin
        cmd.calc_mul = 1'b1;
        div_cnt_nxt  = '0;
        cstate_nxt   = CS_DIV;
      end
      CS_DIV: begin
        cmd.div_step = 1'b1;
        div_cnt_nxt  = div_cnt_r + CNT_W'(1);
        if (div_cnt_r == CNT_W'(DIV_STEPS - 1)) begin
          cstate_nxt = CS_DONE;
        end
      end
      CS_DONE: begin
        // hold the result until the output register is free
        if (!out_valid_r || !out_stall) begin
          cmd.emit      = 1'b1;
          out_valid_nxt = 1'b1;
          cstate_nxt    = CS_IDLE;
        end
      end
      default: cstate_nxt = CS_IDLE;
    endcase
  end

endmodule

// File: design/lpsd_dp.sv
// ----------------------------------------------------------------------------
// lpsd_dp
// Angle/distance registers, span multiply, serial divider and result register.
// ----------------------------------------------------------------------------
module lpsd_dp (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [lpsd_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpsd_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic [7:0]                      in_rx_byte,
  input  lpsd_pkg::dp_cmd_t               cmd,
  output lpsd_pkg::dp_status_t            status,
  output logic [15:0]                     out_angle,
  output logic [15:0]                     out_distance_raw,
  output logic                            out_revolution_start,
  output logic                            out_previous_scan_complete
);
  import lpsd_pkg::*;

  logic [15:0]       min_dist_r;
  logic [7:0]        first_lo_r, first_hi_r, last_lo_r, last_hi_r;
  logic [7:0]        dist_lo_r, dist_hi_r;
  logic [SPAN_W-1:0] start_r, span_r;
  logic [7:0]        mul_idx_r, divisor_r;
  logic [PROD_W-1:0] quo_r;
  logic [7:0]        rem_r;
  logic [15:0]       prev_angle_r;
  logic              boundary_r;
  logic [15:0]       angle_q_r, dist_q_r;
  logic              rev_q_r, done_q_r;

  logic [SPAN_W-1:0] start_w, end_w, span_w;
  logic [8:0]        rem_sh;
  logic              rem_ge;
  logic [15:0]       angle_w;
  logic              rev_w;

  assign status.dist_gt = {dist_hi_r, dist_lo_r} > min_dist_r;

  assign start_w = {first_hi_r, first_lo_r[7:1]};
  assign end_w   = {last_hi_r, last_lo_r[7:1]};
  assign span_w  = (end_w >= start_w) ? (end_w - start_w)
                                      : (end_w + FULL_TURN - start_w);

  assign rem_sh  = {rem_r, quo_r[PROD_W-1]};
  assign rem_ge  = rem_sh >= {1'b0, divisor_r};
  assign angle_w = {1'b0, start_r} + {1'b0, quo_r[SPAN_W-1:0]};
  assign rev_w   = ({1'b0, angle_w} + HALF_TURN) < {1'b0, prev_angle_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_dist_r <= MIN_DIST_RST;
    end else if (cfg_we && cfg_index == CFG_MIN_DIST) begin
      min_dist_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ld_first_lo) first_lo_r <= in_rx_byte;
    if (cmd.ld_first_hi) first_hi_r <= in_rx_byte;
    if (cmd.ld_last_lo)  last_lo_r  <= in_rx_byte;
    if (cmd.ld_last_hi)  last_hi_r  <= in_rx_byte;
    if (cmd.ld_dist_lo)  dist_lo_r  <= in_rx_byte;
    if (cmd.ld_dist_hi)  dist_hi_r  <= in_rx_byte;
    if (cmd.calc_start) begin
      start_r   <= start_w;
      span_r    <= span_w;
      mul_idx_r <= cmd.sample_idx;
      // a single-sample packet has index 0, so dividing by one gives start
      divisor_r <= (cmd.sample_total <= 8'd1) ? 8'd1 : cmd.sample_total - 8'd1;
    end
    if (cmd.calc_mul) begin
      quo_r <= PROD_W'(span_r) * PROD_W'(mul_idx_r);
      rem_r <= 8'd0;
    end else if (cmd.div_step) begin
      quo_r <= {quo_r[PROD_W-2:0], rem_ge};
      rem_r <= rem_ge ? 8'(rem_sh - {1'b0, divisor_r}) : rem_sh[7:0];
    end
    if (cmd.emit) begin
      angle_q_r <= angle_w;
      dist_q_r  <= {dist_hi_r, dist_lo_r};
      rev_q_r   <= rev_w;
      done_q_r  <= rev_w && boundary_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_angle_r <= 16'd0;
      boundary_r   <= 1'b0;
    end else if (cmd.emit) begin
      prev_angle_r <= angle_w;
      if (rev_w) begin
        boundary_r <= 1'b1;
      end
    end
  end

  assign out_angle                  = angle_q_r;
  assign out_distance_raw           = dist_q_r;
  assign out_revolution_start       = rev_q_r;
  assign out_previous_scan_complete = done_q_r;

endmodule

// File: verif/lidar_packet_sample_decoder_tb.sv
// ----------------------------------------------------------------------------
// lidar_packet_sample_decoder_tb
// Self-checking bench: feeds framed byte streams with random idling on both
// channels, predicts every emitted sample and compares it field by field.
// ----------------------------------------------------------------------------
module lidar_packet_sample_decoder_tb;
  import lpsd_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 1000;
  localparam int unsigned SETTLE_CYCLES  = 40;
  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 2'd3;

  typedef struct packed {
    logic [15:0] angle;
    logic [15:0] distance_raw;
    logic        revolution_start;
    logic        previous_scan_complete;
  } sample_t;

  typedef struct packed {
    logic [7:0] rx;
    logic       typed;
    sample_t    want;
  } stim_row_t;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;
  logic                  in_valid   = 1'b0;
  logic [7:0]            in_rx_byte = '0;
  logic                  out_stall  = 1'b0;
  logic                  in_stall;
  logic                  out_valid;
  logic [15:0]           out_angle;
  logic [15:0]           out_distance_raw;
  logic                  out_revolution_start;
  logic                  out_previous_scan_complete;

  lidar_packet_sample_decoder dut (
    .clk                        (clk),
    .rst_n                      (rst_n),
    .cfg_we                     (cfg_we),
    .cfg_index                  (cfg_index),
    .cfg_wdata                  (cfg_wdata),
    .in_valid                   (in_valid),
    .in_stall                   (in_stall),
    .in_rx_byte                 (in_rx_byte),
    .out_valid                  (out_valid),
    .out_stall                  (out_stall),
    .out_angle                  (out_angle),
    .out_distance_raw           (out_distance_raw),
    .out_revolution_start       (out_revolution_start),
    .out_previous_scan_complete (out_previous_scan_complete)
  );

  // predictor state
  parse_phase_t hunt_phase;
  logic [2:0]   hdr_pos;
  logic [7:0]   total;
  logic [7:0]   idx;
  logic [1:0]   byte_pos;
  logic [15:0]  first_word;
  logic [15:0]  last_word;
  logic [15:0]  dist_word;
  logic [15:0]  prev_angle;
  logic         boundary_seen;
  logic [7:0]   lim_samples;
  logic [15:0]  min_dist;

  sample_t     expected_samples [$];
  int unsigned errors          = 0;
  int unsigned samples_checked = 0;
  int unsigned rev_count       = 0;
  int unsigned scan_count      = 0;
  int unsigned packet_bytes    = 0;
  int unsigned settings_used   = 1;
  int unsigned out_hold        = 0;
  int unsigned quiet_cycles    = 0;
  bit          throttle        = 1'b1;

  stim_row_t directed_rows [34] = '{
    '{8'h00, 1'b0, '0},                                      // noise while hunting
    '{8'hAA, 1'b0, '0}, '{8'hAA, 1'b0, '0},                  // repeated AA
    '{8'h55, 1'b0, '0}, '{8'hFF, 1'b0, '0},                  // type byte
    '{8'h01, 1'b0, '0},                                      // one sample
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},                  // start word FFFF
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0},                  // header pattern as payload
    '{8'hAA, 1'b1, '{16'd32767, 16'd21930, 1'b0, 1'b0}},
    '{8'hAA, 1'b0, '0}, '{8'h13, 1'b0, '0},                  // broken header
    '{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h79, 1'b0, '0},                  // count above limit
    '{8'h55, 1'b0, '0},
    '{8'hAA, 1'b0, '0}, '{8'h55, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h02, 1'b0, '0},
    '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0},                  // start 0, end 1
    '{8'h02, 1'b0, '0}, '{8'h00, 1'b0, '0},
    '{8'h50, 1'b0, '0}, '{8'h00, 1'b0, '0}, '{8'h00, 1'b0, '0}, // on the threshold
    '{8'hFF, 1'b0, '0}, '{8'hFF, 1'b0, '0},
    '{8'hFF, 1'b1, '{16'd1, 16'd65535, 1'b1, 1'b0}}
  };

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void clear_model();
    lim_samples   = MAX_SAMPLES_RST;
    min_dist      = MIN_DIST_RST;
    hunt_phase    = PH_WAIT1;
    hdr_pos       = '0;
    total         = '0;
    idx           = '0;
    byte_pos      = '0;
    first_word    = '0;
    last_word     = '0;
    dist_word     = '0;
    prev_angle    = '0;
    boundary_seen = 1'b0;
  endfunction

  function automatic void back_to_hunt();
    hunt_phase = PH_WAIT1;
    hdr_pos    = '0;
    idx        = '0;
    byte_pos   = '0;
  endfunction

  function automatic logic [15:0] interp_angle();
    int unsigned s;
    int unsigned e;
    int unsigned span;
    s = first_word[15:1];
    e = last_word[15:1];
    if (total <= 8'd1) return 16'(s);
    span = (e >= s) ? e - s : e + 32'(FULL_TURN) - s;
    return 16'(s + (span * idx) / (total - 8'd1));
  endfunction

  function automatic void decode_rx_byte(input logic [7:0] b, output bit hit,
                                         output sample_t res);
    logic [15:0] ang;
    logic        rev;
    hit = 1'b0;
    res = '0;
    case (hunt_phase)
      PH_WAIT1: begin
        if (b == HDR_FIRST) hunt_phase = PH_WAIT2;
      end
      PH_WAIT2: begin
        if (b == HDR_SECOND) begin
          hunt_phase = PH_META;
          hdr_pos    = '0;
        end else if (b != HDR_FIRST) begin
          hunt_phase = PH_WAIT1;
        end
      end
      PH_META: begin
        if (hdr_pos == 3'd0) begin
          hdr_pos = 3'd1;                   // type byte skipped
        end else if (b == 8'd0 || b > lim_samples) begin
          back_to_hunt();
        end else begin
          total      = b;
          idx        = '0;
          byte_pos   = '0;
          hdr_pos    = '0;
          hunt_phase = PH_PAYLOAD;
        end
      end
      default: begin
        if (hdr_pos < 3'd4) begin
          case (hdr_pos)
            3'd0:    first_word = {8'h00, b};
            3'd1:    first_word[15:8] = b;
            3'd2:    last_word = {8'h00, b};
            default: last_word[15:8] = b;
          endcase
          hdr_pos = hdr_pos + 3'd1;
        end else if (byte_pos == 2'd0) begin
          dist_word = {8'h00, b};
          byte_pos  = 2'd1;
        end else if (byte_pos == 2'd1) begin
          dist_word[15:8] = b;
          byte_pos        = 2'd2;
        end else begin
          if (dist_word > min_dist) begin
            ang = interp_angle();
            rev = (32'(ang) + 32'(HALF_TURN)) < 32'(prev_angle);
            res = '{ang, dist_word, rev, rev & boundary_seen};
            if (rev) boundary_seen = 1'b1;
            prev_angle = ang;
            hit        = 1'b1;
          end
          byte_pos = '0;
          idx      = idx + 8'd1;
          if (idx >= total) back_to_hunt();
        end
      end
    endcase
  endfunction

  function automatic void note_expected(input sample_t s);
    expected_samples = {expected_samples, s};
  endfunction

  // result side: check, random stall bursts, watchdog count
  always @(posedge clk) begin
    sample_t want;
    if (!rst_n) begin
      out_stall    <= 1'b0;
      quiet_cycles <= 0;
      out_hold      = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_samples.size() == 0) begin
          $error("sample with nothing outstanding: angle %0d distance %0d",
                 out_angle, out_distance_raw);
          errors++;
        end else begin
          want = expected_samples.pop_front();
          if (out_angle !== want.angle) begin
            $error("angle: expected %0d, got %0d", want.angle, out_angle);
            errors++;
          end
          if (out_distance_raw !== want.distance_raw) begin
            $error("distance_raw: expected %0d, got %0d", want.distance_raw,
                   out_distance_raw);
            errors++;
          end
          if (out_revolution_start !== want.revolution_start) begin
            $error("revolution_start: expected %0d, got %0d", want.revolution_start,
                   out_revolution_start);
            errors++;
          end
          if (out_previous_scan_complete !== want.previous_scan_complete) begin
            $error("previous_scan_complete: expected %0d, got %0d",
                   want.previous_scan_complete, out_previous_scan_complete);
            errors++;
          end
          samples_checked++;
          rev_count  += want.revolution_start;
          scan_count += want.previous_scan_complete;
        end
      end
      quiet_cycles <= ((in_valid && !in_stall) || (out_valid && !out_stall)) ?
                      0 : quiet_cycles + 1;
      if (out_hold > 0) begin
        out_hold--;
        out_stall <= 1'b1;
      end else if (throttle && $urandom_range(0, 7) == 0) begin
        out_hold   = $urandom_range(0, 8);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    while (quiet_cycles < WATCHDOG_LIMIT) @(posedge clk);
    $display("no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("FAIL");
    $finish;
  end

  // called at a clock edge; returns at the edge where the byte was taken
  task automatic offer_byte(input logic [7:0] b, input logic typed, input sample_t fixed);
    bit      hit;
    sample_t got;
    if (throttle && $urandom_range(0, 9) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_rx_byte <= b;
    do @(posedge clk); while (in_stall !== 1'b0);
    decode_rx_byte(b, hit, got);
    if (typed) note_expected(fixed);
    else if (hit) note_expected(got);
  endtask

  task automatic put_byte(input logic [7:0] b);
    offer_byte(b, 1'b0, '0);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] i, input logic [CFG_DATA_W-1:0] d);
    cfg_we    <= 1'b1;
    cfg_index <= i;
    cfg_wdata <= d;
    @(posedge clk);
    case (i)
      CFG_MAX_SAMPLES: lim_samples = d[7:0];
      CFG_MIN_DIST:    min_dist    = d;
      default: ;
    endcase
  endtask

  task automatic configure(input logic [7:0] max_n, input logic [15:0] min_d,
                           input bit poke_spare);
    drain();
    cfg_write(CFG_MAX_SAMPLES, {8'($urandom), max_n});
    cfg_write(CFG_MIN_DIST, min_d);
    if (poke_spare) begin
      cfg_write(CFG_SPARE_LO, 16'($urandom));
      cfg_write(CFG_SPARE_HI, 16'($urandom));
    end
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // a count right at the limit only when the limit is small; the full-size
  // packet is sent once on its own
  function automatic int unsigned pick_count();
    int unsigned top;
    top = (lim_samples < 8'd6) ? lim_samples : 6;
    if (lim_samples <= 8'd20 && $urandom_range(0, 29) == 0) return lim_samples;
    return $urandom_range(1, top);
  endfunction

  task automatic send_packet(input int unsigned n);
    logic [15:0] w;
    logic [15:0] d;
    put_byte(HDR_FIRST);
    put_byte(HDR_SECOND);
    put_byte(8'($urandom));
    put_byte(8'(n));
    repeat (2) begin
      w = 16'($urandom);
      put_byte(w[7:0]);
      put_byte(w[15:8]);
    end
    repeat (n) begin
      case ($urandom_range(0, 5))
        0:       d = min_dist;
        1:       d = min_dist + 16'd1;
        2:       d = 16'hFFFF;
        3:       d = 16'h0000;
        default: d = 16'($urandom);
      endcase
      put_byte(d[7:0]);
      put_byte(d[15:8]);
      put_byte(8'($urandom));
    end
    packet_bytes += 8 + 3 * n;
  endtask

  task automatic send_junk();
    int unsigned n;
    logic [7:0]  bad_count;
    case ($urandom_range(0, 4))
      0: begin
        n = $urandom_range(1, 6);
        repeat (n) put_byte(8'($urandom));
      end
      1: begin
        put_byte(HDR_FIRST);
        put_byte(8'($urandom));
      end
      2: begin
        put_byte(HDR_FIRST);
        put_byte(HDR_FIRST);
      end
      default: begin
        // header then a count of zero or a count above the limit
        bad_count = 8'd0;
        if (lim_samples != 8'hFF && $urandom_range(0, 1) == 1)
          bad_count = 8'($urandom_range(lim_samples + 1, 255));
        put_byte(HDR_FIRST);
        put_byte(HDR_SECOND);
        put_byte(8'($urandom));
        put_byte(bad_count);
      end
    endcase
  endtask

  task automatic run_phase(input int unsigned budget);
    int unsigned base;
    int unsigned r;
    base = packet_bytes;
    while (packet_bytes - base < budget) begin
      r = $urandom_range(0, 9);
      if (r < 2) send_junk();
      else send_packet(pick_count());
      if (r == 9) drain();
    end
  endtask

  initial begin
    clear_model();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_rows[k])
      offer_byte(directed_rows[k].rx, directed_rows[k].typed, directed_rows[k].want);
    run_phase(20);

    configure(8'd255, 16'd0, 1'b1);
    send_packet(255);
    run_phase(10);

    configure(8'd1, 16'hFFFF, 1'b0);
    run_phase(20);

    configure(8'($urandom_range(2, 20)), 16'($urandom_range(0, 4000)), 1'b1);
    run_phase(20);

    // closing stretch at full rate
    throttle = 1'b0;
    configure(MAX_SAMPLES_RST, MIN_DIST_RST, 1'b0);
    run_phase(20);
    drain();

    $display("%0d packet bytes over %0d register settings, %0d samples compared",
             packet_bytes, settings_used, samples_checked);
    $display("revolution starts: %0d, completed scans flagged: %0d", rev_count, scan_count);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: lidar_packet_sample_decoder.f
+incdir+design
design/lpsd_pkg.sv
design/lpsd_ctrl.sv
design/lpsd_dp.sv
design/lidar_packet_sample_decoder.sv
verif/lidar_packet_sample_decoder_tb.sv
